>>> sv/saturated_pd_point_mass_step_defines.svh
// Assertion macros shared by the point-mass step block.
// No dependencies; included by the files that carry assertions.
`ifndef SATURATED_PD_POINT_MASS_STEP_DEFINES_SVH
`define SATURATED_PD_POINT_MASS_STEP_DEFINES_SVH

// Same-cycle implication, switched off during reset.
`define SPMS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off during reset.
`define SPMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/spms_pkg.sv
// Types, codes and helper functions of the point-mass step block.
// No dependencies; used by every other file of the block but the assertion macro header.
package spms_pkg;

    localparam int unsigned AXES = 3;

    localparam logic [1:0] CFG_POS_GAIN  = 2'd0;
    localparam logic [1:0] CFG_VEL_GAIN  = 2'd1;
    localparam logic [1:0] CFG_MAX_ACCEL = 2'd2;
    localparam logic [1:0] CFG_STEP_SIZE = 2'd3;

    localparam logic [30:0] STEP_SIZE_RESET = 31'd65536;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] aim_pos_x;
        logic signed [31:0] aim_pos_y;
        logic signed [31:0] aim_pos_z;
        logic signed [31:0] aim_vel_x;
        logic signed [31:0] aim_vel_y;
        logic signed [31:0] aim_vel_z;
        logic [30:0]        target_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        sim_time;
        logic               clamped;
        logic               reached_end;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHK, ST_MPOS, ST_MVEL, ST_ACC, ST_SQR, ST_SQACC, ST_MAXSQ,
        ST_CMP, ST_SQRT, ST_MMAG, ST_DIVINIT, ST_DIV, ST_SCALE, ST_EPOS,
        ST_EVEL, ST_WVEL, ST_TIME, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_LOAD, OP_SETUP, OP_MPOS, OP_MVEL, OP_ACC,
        OP_SQR, OP_SQACC, OP_MAXSQ, OP_CMP, OP_SQRT, OP_MMAG, OP_DIVINIT,
        OP_DIV, OP_SCALE, OP_EPOS, OP_EVEL, OP_WVEL, OP_TIME, OP_PUBLISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] ax;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic no_time;
        logic limit;
    } t_dp_sts;

    localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
    localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

    // Clip a wide signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> sv/spms_ifs.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on spms_pkg for the payload types.
interface spms_in_if import spms_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spms_out_if import spms_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/spms_ctrl.sv
// Sequencer of the point-mass step block: state machine, axis and iteration counters.
// Depends on spms_pkg and the assertion macro header.
`include "saturated_pd_point_mass_step_defines.svh"

module spms_ctrl import spms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state     r_state, n_state;
    logic [1:0] r_ax, n_ax;
    logic [4:0] r_cnt, n_cnt;
    logic       r_ovalid, n_ovalid;
    logic       c_pub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ax     <= 2'd0;
            r_cnt    <= 5'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ax     <= n_ax;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ax       = r_ax;
        n_cnt      = r_cnt;
        o_cmd.op   = OP_NONE;
        o_cmd.ax   = r_ax;
        o_in_ready = 1'b0;
        c_pub      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = ST_CHK;
                end
            end
            ST_CHK: begin
                n_ax = 2'd0;
                if (!i_sts.kind) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_DONE;
                end else if (i_sts.no_time) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.op = OP_SETUP;
                    n_state  = ST_MPOS;
                end
            end
            ST_MPOS: begin
                o_cmd.op = OP_MPOS;
                n_state  = ST_MVEL;
            end
            ST_MVEL: begin
                o_cmd.op = OP_MVEL;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = ST_SQR;
            end
            ST_SQR: begin
                o_cmd.op = OP_SQR;
                n_state  = ST_SQACC;
            end
            ST_SQACC: begin
                o_cmd.op = OP_SQACC;
                if (r_ax == 2'd2) begin
                    n_ax    = 2'd0;
                    n_state = ST_MAXSQ;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = ST_MPOS;
                end
            end
            ST_MAXSQ: begin
                o_cmd.op = OP_MAXSQ;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.op = OP_CMP;
                n_cnt    = 5'd0;
                n_state  = i_sts.limit ? ST_SQRT : ST_EPOS;
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = ST_MMAG;
                end
            end
            ST_MMAG: begin
                o_cmd.op = OP_MMAG;
                n_state  = ST_DIVINIT;
            end
            ST_DIVINIT: begin
                o_cmd.op = OP_DIVINIT;
                n_cnt    = 5'd0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.op = OP_SCALE;
                if (r_ax == 2'd2) begin
                    n_ax    = 2'd0;
                    n_state = ST_EPOS;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = ST_MMAG;
                end
            end
            ST_EPOS: begin
                o_cmd.op = OP_EPOS;
                n_state  = ST_EVEL;
            end
            ST_EVEL: begin
                o_cmd.op = OP_EVEL;
                n_state  = ST_WVEL;
            end
            ST_WVEL: begin
                o_cmd.op = OP_WVEL;
                if (r_ax == 2'd2) begin
                    n_ax    = 2'd0;
                    n_state = ST_TIME;
                end else begin
                    n_ax    = r_ax + 2'd1;
                    n_state = ST_EPOS;
                end
            end
            ST_TIME: begin
                o_cmd.op = OP_TIME;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = OP_PUBLISH;
                    c_pub    = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_ovalid = c_pub | (r_ovalid & ~i_out_ready);
    end

    assign o_out_valid = r_ovalid;

    `SPMS_ASSERT_NEXT(a_accept_goes_chk, i_clk, i_rst_n, r_state == ST_IDLE && i_in_valid, r_state == ST_CHK, "accepted item did not start")
    `SPMS_ASSERT_NOW(a_axis_range, i_clk, i_rst_n, 1'b1, r_ax != 2'd3, "axis counter out of range")
    `SPMS_ASSERT_NEXT(a_publish_valid, i_clk, i_rst_n, c_pub, r_ovalid && r_state == ST_IDLE, "published result not offered")
    `SPMS_ASSERT_NOW(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == ST_IDLE, "input ready outside idle")

endmodule

>>> sv/spms_dp.sv
// Datapath of the point-mass step block: configuration, state, one shared
// multiplier, a bit-serial square root and a bit-serial divider. Depends on spms_pkg.
module spms_dp import spms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  t_in_item    i_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output t_out_item   o_result
);

    logic signed [31:0] r_pg, r_vg;
    logic [30:0]        r_max, r_step;

    logic signed [31:0] r_pos [AXES];
    logic signed [31:0] r_vel [AXES];
    logic [30:0]        r_time;

    logic               r_kind;
    logic signed [31:0] r_aim_pos [AXES];
    logic signed [31:0] r_aim_vel [AXES];
    logic [30:0]        r_end;

    logic [30:0]        r_h;
    logic signed [31:0] r_acc [AXES];
    logic signed [63:0] r_prod;
    logic signed [47:0] r_term;
    logic [63:0]        r_nsq;
    logic               r_clamped;
    logic [63:0]        r_rad;
    logic [32:0]        r_rem;
    logic [31:0]        r_root;
    logic [31:0]        r_drem;
    logic [31:0]        r_dq;
    t_out_item          r_out;

    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_mul;
    logic signed [47:0] w_fl;
    logic signed [31:0] w_acc, w_pos, w_vel;
    logic [31:0]        w_mag;
    logic [30:0]        w_stp, w_remain;
    logic [34:0]        w_rsh, w_rtr;
    logic [32:0]        w_dt;
    logic               w_dge;

    assign w_acc = r_acc[i_cmd.ax];
    assign w_pos = r_pos[i_cmd.ax];
    assign w_vel = r_vel[i_cmd.ax];
    assign w_mag = w_acc[31] ? (~w_acc + 32'd1) : w_acc;
    assign w_fl  = r_prod[63:16];

    // Operand selection of the shared multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.op)
            OP_MPOS: begin
                w_ma = 34'(r_pg);
                w_mb = 34'(w_pos) - 34'(r_aim_pos[i_cmd.ax]);
            end
            OP_MVEL: begin
                w_ma = 34'(r_vg);
                w_mb = 34'(w_vel) - 34'(r_aim_vel[i_cmd.ax]);
            end
            OP_SQR: begin
                w_ma = 34'(w_acc);
                w_mb = 34'(w_acc);
            end
            OP_MAXSQ: begin
                w_ma = {3'b000, r_max};
                w_mb = {3'b000, r_max};
            end
            OP_MMAG: begin
                w_ma = {2'b00, w_mag};
                w_mb = {3'b000, r_max};
            end
            OP_EPOS: begin
                w_ma = {3'b000, r_h};
                w_mb = 34'(w_vel);
            end
            OP_EVEL: begin
                w_ma = {3'b000, r_h};
                w_mb = 34'(w_acc);
            end
            default: begin
                w_ma = '0;
            end
        endcase
    end

    assign w_mul = w_ma * w_mb;

    assign w_stp    = (r_step == 31'd0) ? 31'd1 : r_step;
    assign w_remain = r_end - r_time;

    assign w_rsh = {r_rem, r_rad[63:62]};
    assign w_rtr = {1'b0, r_root, 2'b01};
    assign w_dt  = {r_drem, r_dq[31]};
    assign w_dge = w_dt >= {1'b0, r_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg   <= '0;
            r_vg   <= '0;
            r_max  <= '0;
            r_step <= STEP_SIZE_RESET;
            r_time <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POS_GAIN:  r_pg   <= i_cfg_data;
                    CFG_VEL_GAIN:  r_vg   <= i_cfg_data;
                    CFG_MAX_ACCEL: r_max  <= i_cfg_data[30:0];
                    CFG_STEP_SIZE: r_step <= i_cfg_data[30:0];
                    default:       r_pg   <= r_pg;
                endcase
            end
            if (i_cmd.op == OP_LOAD) begin
                for (int i = 0; i < AXES; i++) begin
                    r_pos[i] <= r_aim_pos[i];
                    r_vel[i] <= r_aim_vel[i];
                end
                r_time <= r_end;
            end
            if (i_cmd.op == OP_EVEL) begin
                r_pos[i_cmd.ax] <= sat32(49'(w_pos) + 49'(w_fl));
            end
            if (i_cmd.op == OP_WVEL) begin
                r_vel[i_cmd.ax] <= sat32(49'(w_vel) + 49'(w_fl));
            end
            if (i_cmd.op == OP_TIME) begin
                r_time <= r_time + r_h;
            end
        end
    end

    // Working registers: no reset needed, every item sets them before use.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_kind       <= i_item.kind;
                r_aim_pos[0] <= i_item.aim_pos_x;
                r_aim_pos[1] <= i_item.aim_pos_y;
                r_aim_pos[2] <= i_item.aim_pos_z;
                r_aim_vel[0] <= i_item.aim_vel_x;
                r_aim_vel[1] <= i_item.aim_vel_y;
                r_aim_vel[2] <= i_item.aim_vel_z;
                r_end        <= i_item.target_time;
                r_clamped    <= 1'b0;
            end
            OP_SETUP: begin
                r_h   <= (w_stp > w_remain) ? w_remain : w_stp;
                r_nsq <= '0;
            end
            OP_MPOS, OP_SQR, OP_MAXSQ, OP_MMAG, OP_EPOS: begin
                r_prod <= w_mul[63:0];
            end
            OP_MVEL: begin
                r_term <= w_fl;
                r_prod <= w_mul[63:0];
            end
            OP_EVEL: begin
                r_prod <= w_mul[63:0];
            end
            OP_ACC: begin
                r_acc[i_cmd.ax] <= sat32(49'(r_term) + 49'(w_fl));
            end
            OP_SQACC: begin
                r_nsq <= r_nsq + r_prod;
            end
            OP_CMP: begin
                r_clamped <= o_sts.limit;
                r_rad     <= r_nsq;
                r_rem     <= '0;
                r_root    <= '0;
            end
            OP_SQRT: begin
                // One result bit per cycle, two radicand bits shifted in.
                r_rad <= {r_rad[61:0], 2'b00};
                if (w_rsh >= w_rtr) begin
                    r_rem  <= 33'(w_rsh - w_rtr);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_rsh[32:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            OP_DIVINIT: begin
                r_drem <= r_prod[63:32];
                r_dq   <= r_prod[31:0];
            end
            OP_DIV: begin
                r_drem <= w_dge ? 32'(w_dt - {1'b0, r_root}) : w_dt[31:0];
                r_dq   <= {r_dq[30:0], w_dge};
            end
            OP_SCALE: begin
                r_acc[i_cmd.ax] <= w_acc[31] ? (~r_dq + 32'd1) : r_dq;
            end
            OP_PUBLISH: begin
                r_out.pos_x       <= r_pos[0];
                r_out.pos_y       <= r_pos[1];
                r_out.pos_z       <= r_pos[2];
                r_out.vel_x       <= r_vel[0];
                r_out.vel_y       <= r_vel[1];
                r_out.vel_z       <= r_vel[2];
                r_out.sim_time    <= r_time;
                r_out.clamped     <= r_clamped;
                r_out.reached_end <= r_time >= r_end;
            end
            default: begin
                r_term <= r_term;
            end
        endcase
    end

    assign o_sts.kind    = r_kind;
    assign o_sts.no_time = r_end <= r_time;
    assign o_sts.limit   = r_nsq > r_prod;
    assign o_result      = r_out;

endmodule

>>> sv/saturated_pd_point_mass_step.sv
// Top level of the saturated PD point-mass step block.
// Depends on spms_pkg, spms_ifs, spms_ctrl and spms_dp.

// The block holds a 3-D position and velocity in signed Q16.16 and a time in
// unsigned Q15.16, and returns one result item for every input item. A load
// item (kind 0) sets the state from its fields; a step item (kind 1) forms a PD
// acceleration from the aiming position and velocity, limits its magnitude to
// max_accel and takes one explicit Euler step of min(step_size, target time -
// time). Items are handled one at a time by a sequencer driving a datapath
// built round one shared 34 by 34 bit multiplier. A load item, or a step with
// no time left, goes straight from the check state to the result; a step
// whose acceleration stays within the limit runs the control law and the norm
// axis by axis, then the integration axis by axis. When the limit applies, a
// bit-serial square root and, per axis, a bit-serial divider scale the
// acceleration down before the integration. A finished result waits in an
// output register, and the next item may be accepted while it waits.
// Configuration registers are written through a plain write port and must be
// written only while the block is idle.
module saturated_pd_point_mass_step import spms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spms_in_if.sink     i_item,
    spms_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer: owns the handshakes and walks the datapath through an item.
    spms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Datapath: configuration, state, arithmetic and the result register.
    spms_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item.data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_result   (o_result.data)
    );

endmodule

>>> verif/spms_checker.sv
// Result checker of the point-mass step block: it follows the configuration port and
// both channels, predicts every result item and compares it field by field.
// Depends on spms_pkg for the item types and register indexes.
module spms_checker import spms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    // Tracker state and registers at full software widths.
    longint            trk_pos [3];
    longint            trk_vel [3];
    longint            trk_now;
    longint            gain_p;
    longint            gain_v;
    longint unsigned   accel_lim;
    longint            nominal_step;
    t_out_item         awaited_results [$];
    int                awaiting;
    int                fails;

    assign o_fail_count = fails;
    assign o_pending    = awaiting;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Applies one input item to the tracker and returns the result it causes.
    function automatic t_out_item advance_tracker(t_in_item it);
        longint          aim_p [3];
        longint          aim_v [3];
        longint          acc [3];
        longint          fin;
        longint          h;
        longint          np;
        longint unsigned nsq;
        longint unsigned norm;
        longint unsigned q;
        logic            lim;
        t_out_item       r;
        aim_p[0] = it.aim_pos_x;
        aim_p[1] = it.aim_pos_y;
        aim_p[2] = it.aim_pos_z;
        aim_v[0] = it.aim_vel_x;
        aim_v[1] = it.aim_vel_y;
        aim_v[2] = it.aim_vel_z;
        fin = longint'({33'd0, it.target_time});
        lim = 1'b0;
        if (!it.kind) begin
            for (int i = 0; i < 3; i++) begin
                trk_pos[i] = aim_p[i];
                trk_vel[i] = aim_v[i];
            end
            trk_now = fin;
        end else if (fin > trk_now) begin
            h = (nominal_step == 0) ? 1 : nominal_step;
            if (h > fin - trk_now) h = fin - trk_now;
            nsq = 0;
            for (int i = 0; i < 3; i++) begin
                acc[i] = clip32(((gain_p * (trk_pos[i] - aim_p[i])) >>> 16)
                              + ((gain_v * (trk_vel[i] - aim_v[i])) >>> 16));
                nsq = nsq + abs64(acc[i]) * abs64(acc[i]);
            end
            if (nsq > accel_lim * accel_lim) begin
                norm = floor_root(nsq);
                lim = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    q = (abs64(acc[i]) * accel_lim) / norm;
                    acc[i] = (acc[i] < 0) ? -longint'(q) : longint'(q);
                end
            end
            for (int i = 0; i < 3; i++) begin
                np = clip32(trk_pos[i] + ((h * trk_vel[i]) >>> 16));
                trk_vel[i] = clip32(trk_vel[i] + ((h * acc[i]) >>> 16));
                trk_pos[i] = np;
            end
            trk_now = trk_now + h;
        end
        r.pos_x       = trk_pos[0][31:0];
        r.pos_y       = trk_pos[1][31:0];
        r.pos_z       = trk_pos[2][31:0];
        r.vel_x       = trk_vel[0][31:0];
        r.vel_y       = trk_vel[1][31:0];
        r.vel_z       = trk_vel[2][31:0];
        r.sim_time    = trk_now[30:0];
        r.clamped     = lim;
        r.reached_end = (trk_now >= fin);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_out_item w;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                trk_pos[i] = 0;
                trk_vel[i] = 0;
            end
            trk_now      = 0;
            gain_p       = 0;
            gain_v       = 0;
            accel_lim    = 0;
            nominal_step = longint'(STEP_SIZE_RESET);
            awaited_results.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POS_GAIN:  gain_p = longint'(signed'(i_cfg_data));
                    CFG_VEL_GAIN:  gain_v = longint'(signed'(i_cfg_data));
                    CFG_MAX_ACCEL: accel_lim = {33'd0, i_cfg_data[30:0]};
                    CFG_STEP_SIZE: nominal_step = longint'({33'd0, i_cfg_data[30:0]});
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result item with none expected", $realtime);
                    fails++;
                end else begin
                    w = awaited_results.pop_front();
                    if (i_out_data.pos_x !== w.pos_x)
                        report_mismatch("pos_x", i_out_data.pos_x, w.pos_x);
                    if (i_out_data.pos_y !== w.pos_y)
                        report_mismatch("pos_y", i_out_data.pos_y, w.pos_y);
                    if (i_out_data.pos_z !== w.pos_z)
                        report_mismatch("pos_z", i_out_data.pos_z, w.pos_z);
                    if (i_out_data.vel_x !== w.vel_x)
                        report_mismatch("vel_x", i_out_data.vel_x, w.vel_x);
                    if (i_out_data.vel_y !== w.vel_y)
                        report_mismatch("vel_y", i_out_data.vel_y, w.vel_y);
                    if (i_out_data.vel_z !== w.vel_z)
                        report_mismatch("vel_z", i_out_data.vel_z, w.vel_z);
                    if (i_out_data.sim_time !== w.sim_time)
                        report_mismatch("sim_time", i_out_data.sim_time, w.sim_time);
                    if (i_out_data.clamped !== w.clamped)
                        report_mismatch("clamped", i_out_data.clamped, w.clamped);
                    if (i_out_data.reached_end !== w.reached_end)
                        report_mismatch("reached_end", i_out_data.reached_end,
                                        w.reached_end);
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(advance_tracker(i_in_data));
        end
        awaiting = awaited_results.size();
    end

endmodule

>>> verif/testbench.sv
// Top of the point-mass step testbench: clock, reset, stimulus and verdict.
// Depends on spms_pkg, spms_ifs, the block itself and spms_checker.
module testbench;
    import spms_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          ready_hold = 0;
    int          calm_left = 0;

    spms_in_if  item_ch ();
    spms_out_if result_ch ();

    saturated_pd_point_mass_step u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch.sink),
        .o_result   (result_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    spms_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (item_ch.valid),
        .i_in_ready   (item_ch.ready),
        .i_in_data    (item_ch.data),
        .i_out_valid  (result_ch.valid),
        .i_out_ready  (result_ch.ready),
        .i_out_data   (result_ch.data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // The result side stalls at random, now and then for a long stretch, and now and
    // then a calm stretch keeps ready high throughout.
    always @(negedge i_clk) begin
        if (calm_left > 0) begin
            calm_left <= calm_left - 1;
            result_ch.ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            result_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            calm_left <= $urandom_range(50, 400);
            result_ch.ready <= 1'b1;
        end else if ($urandom_range(0, 9) < 3) begin
            ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 2);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // A Q16.16 value: mostly a few units either side of zero, sometimes any pattern.
    function automatic logic signed [31:0] pick_fix();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h000c_0000)) - 32'sh0006_0000;
    endfunction

    // One register write; the caller drops the write enable afterwards.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
    endtask

    // Registers change only while the block is idle: every result must be back.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] kp, logic [31:0] kv, logic [30:0] amax,
                            logic [30:0] hnom);
        wait_drained();
        write_reg(CFG_POS_GAIN, kp);
        write_reg(CFG_VEL_GAIN, kv);
        write_reg(CFG_MAX_ACCEL, {1'b0, amax});
        write_reg(CFG_STEP_SIZE, {1'b0, hnom});
        cfg_we <= 1'b0;
    endtask

    // Offers one item after a random gap; valid stays high when no gap follows.
    task automatic send_item(t_in_item it);
        int gap;
        gap = ($urandom_range(0, 3) != 0) ? 0
            : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3));
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        forever begin
            @(posedge i_clk);
            if (item_ch.ready) break;
        end
        @(negedge i_clk);
    endtask

    task automatic send_fields(logic kind, logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz, logic signed [31:0] vx,
                               logic signed [31:0] vy, logic signed [31:0] vz,
                               logic [30:0] fin);
        t_in_item it;
        it.kind        = kind;
        it.aim_pos_x   = px;
        it.aim_pos_y   = py;
        it.aim_pos_z   = pz;
        it.aim_vel_x   = vx;
        it.aim_vel_y   = vy;
        it.aim_vel_z   = vz;
        it.target_time = fin;
        send_item(it);
    endtask

    // Random step item with random aim and the given target time.
    task automatic send_rand_step(logic [30:0] fin);
        send_fields(1'b1, pick_fix(), pick_fix(), pick_fix(),
                    pick_fix(), pick_fix(), pick_fix(), fin);
    endtask

    initial begin
        int          sent;
        logic [30:0] clock_now;
        logic [30:0] horizon;
        int          run_len;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_POS_GAIN;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With reset registers the gains are zero, so steps only coast.
        send_fields(1'b0, 32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000,
                    32'sh0000_4000, 32'sh0001_0000, -32'sh0000_2000, 31'd0);
        send_rand_step(31'h0002_8000);
        send_rand_step(31'h0002_8000);
        send_rand_step(31'h0002_8000);
        // Extremes of every field on a load, then a step with no time left.
        send_fields(1'b0, 32'sh7fff_ffff, -32'sh8000_0000, 32'sh7fff_ffff,
                    -32'sh8000_0000, 32'sh7fff_ffff, -32'sh8000_0000, 31'h7fff_ffff);
        send_rand_step(31'h7fff_ffff);
        send_rand_step(31'd0);

        // Typical negative gains with a generous limit.
        set_regs(-32'sh0004_0000, -32'sh0002_0000, 31'h0100_0000, 31'h0000_4000);
        send_fields(1'b0, 32'sh0003_0000, 32'sh0001_0000, -32'sh0002_0000,
                    32'sh0, 32'sh0, 32'sh0, 31'h0001_0000);
        send_fields(1'b1, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 31'h0002_0000);
        send_fields(1'b1, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 31'h0002_0000);
        // Tight limit, so the acceleration is scaled down.
        set_regs(-32'sh0010_0000, -32'sh0008_0000, 31'h0000_8000, 31'h0000_8000);
        send_fields(1'b1, 32'sh0010_0000, -32'sh0008_0000, 32'sh0,
                    32'sh0, 32'sh0001_0000, 32'sh0, 31'h0004_0000);
        // Zero limit: any non-zero acceleration shrinks to nothing.
        // Zero step size: behaves as one LSB.
        set_regs(-32'sh0001_0000, -32'sh0001_0000, 31'd0, 31'd0);
        send_rand_step(31'h0010_0000);
        send_rand_step(31'h0010_0000);
        // Gain extremes with saturating state and the largest step and limit.
        set_regs(32'sh7fff_ffff, -32'sh8000_0000, 31'h7fff_ffff, 31'h7fff_ffff);
        send_fields(1'b0, 32'sh7fff_0000, -32'sh7fff_0000, 32'sh1234_5678,
                    32'sh7fff_ffff, -32'sh8000_0000, 32'sh0100_0000, 31'd0);
        send_fields(1'b1, -32'sh8000_0000, 32'sh7fff_ffff, -32'sh8000_0000,
                    -32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, 31'h7fff_ffff);
        send_fields(1'b1, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 31'h7fff_ffff);
        set_regs(-32'sh8000_0000, 32'sh7fff_ffff, 31'h0000_0001, 31'h0000_0001);
        send_rand_step(31'h0000_0010);
        send_rand_step(31'h0000_0010);

        // Random part: a load opens each trajectory, steps march toward a horizon,
        // and a few steps with random targets and past-due steps act as noise.
        // Registers are reshuffled between phases.
        sent = 0;
        clock_now = 31'd0;
        while (sent < 2000) begin
            if (sent % 250 == 0) begin
                case ($urandom_range(0, 4))
                    0: set_regs(-$urandom_range(0, 32'h0008_0000),
                                -$urandom_range(0, 32'h0004_0000),
                                31'($urandom_range(0, 31'h0010_0000)),
                                31'($urandom_range(31'h100, 31'h0001_0000)));
                    1: set_regs(-$urandom_range(0, 32'h0040_0000),
                                -$urandom_range(0, 32'h0040_0000),
                                31'($urandom_range(0, 31'h0000_4000)),
                                31'($urandom_range(0, 31'h0000_4000)));
                    2: set_regs($urandom, $urandom, 31'($urandom), 31'($urandom));
                    3: set_regs(-$urandom_range(0, 32'h0002_0000),
                                -$urandom_range(0, 32'h0002_0000),
                                31'h7fff_ffff, 31'($urandom_range(1, 31'h0004_0000)));
                    default: set_regs(-$urandom_range(0, 32'h0010_0000), $urandom,
                                      31'($urandom_range(0, 31'h0000_1000)),
                                      31'h7fff_ffff);
                endcase
            end
            clock_now = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                    : 31'($urandom_range(0, 31'h0100_0000));
            send_fields(1'b0, pick_fix(), pick_fix(), pick_fix(),
                        pick_fix(), pick_fix(), pick_fix(), clock_now);
            sent++;
            horizon = clock_now + 31'($urandom_range(0, 31'h0008_0000));
            run_len = $urandom_range(1, 12);
            for (int k = 0; k < run_len; k++) begin
                if ($urandom_range(0, 15) == 0)
                    send_rand_step(31'($urandom));
                else if ($urandom_range(0, 9) == 0)
                    send_rand_step(clock_now - 31'($urandom_range(0, 4)));
                else
                    send_rand_step(horizon);
                sent++;
            end
            // Now and then the sender holds off until every result is back.
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end

        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[saturated_pd_point_mass_step] OK");
        end else begin
            $display("[saturated_pd_point_mass_step] ERROR");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #(20 * 8_000_000);
        $display("[saturated_pd_point_mass_step] ERROR");
        $finish;
    end

endmodule
